@@ hdl/sfc_pkg.sv @@
// sensor frame checker package: status codes, register indexes, frame constants
// and the check request / result types shared by the front, queue and back
// no dependencies
package sfc_pkg;

    localparam int unsigned FRAME_LEN  = 11;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [7:0] HDR_SYNC = 8'h55;
    localparam logic [7:0] HDR_TYPE = 8'h03;
    localparam logic [7:0] HDR_LEN  = 8'd11;

    localparam logic [POS_W-1:0] POS_RESERVED = 4'd9;
    localparam logic [POS_W-1:0] POS_CSUM     = 4'd10;
    localparam logic [POS_W-1:0] POS_FULL     = 4'd11;

    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL_THR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LVL_THR    = 2'd2;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_HDR_ERR  = 2'd1,
        ST_INVALID  = 2'd2,
        ST_CSUM_ERR = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [15:0] level;
        logic [15:0] volume;
        logic [7:0]  flag;
        logic [7:0]  mode;
    } t_check_req;

    typedef struct packed {
        t_status     status;
        logic [15:0] level_value;
        logic [15:0] volume_value;
        logic [7:0]  flag_byte;
        logic [7:0]  mode_byte;
        logic        warning;
        logic [7:0]  packet_count;
        logic [15:0] header_errors;
        logic [15:0] invalid_errors;
        logic [15:0] checksum_errors;
    } t_result;

endpackage

@@ hdl/sfc_in_if.sv @@
// input byte channel of the sensor frame checker
// no dependencies
interface sfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       burst_end;

    modport source (output valid, output rx_byte, output burst_end, input ready);
    modport sink   (input valid, input rx_byte, input burst_end, output ready);
endinterface

@@ hdl/sfc_out_if.sv @@
// result channel of the sensor frame checker
// no dependencies
interface sfc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] level_value;
    logic [15:0] volume_value;
    logic [7:0]  flag_byte;
    logic [7:0]  mode_byte;
    logic        warning;
    logic [7:0]  packet_count;
    logic [15:0] header_errors;
    logic [15:0] invalid_errors;
    logic [15:0] checksum_errors;

    modport source (
        output valid, output status, output level_value, output volume_value,
        output flag_byte, output mode_byte, output warning, output packet_count,
        output header_errors, output invalid_errors, output checksum_errors,
        input ready
    );
    modport sink (
        input valid, input status, input level_value, input volume_value,
        input flag_byte, input mode_byte, input warning, input packet_count,
        input header_errors, input invalid_errors, input checksum_errors,
        output ready
    );
endinterface

@@ hdl/sfc_front.sv @@
// front end: collects burst bytes into the frame store, keeps a running checksum
// and classifies the frame on the last byte; depends on sfc_pkg
module sfc_front
    import sfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_burst_end,
    output logic       o_ready,
    input  logic       i_q_full,
    output logic       o_push,
    output t_check_req o_req
);

    logic [7:0]       r_store [FRAME_LEN];
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       r_sum;
    logic [7:0]       n_sum;
    logic [7:0]       w_frame [FRAME_LEN];
    logic [7:0]       w_old;
    logic             w_accept;
    logic             w_in_frame;

    assign o_ready    = !i_q_full;
    assign w_accept   = i_valid && o_ready;
    assign w_in_frame = r_pos < POS_FULL;
    assign w_old      = w_in_frame ? r_store[r_pos] : 8'd0;

    // frame as it stands once the current byte is written
    always_comb begin
        for (int k = 0; k < FRAME_LEN; k++) begin
            w_frame[k] = (r_pos == POS_W'(k)) ? i_rx_byte : r_store[k];
        end
    end

    always_comb begin
        n_sum = r_sum;
        if (r_pos < POS_CSUM) begin
            n_sum = r_sum - w_old + i_rx_byte;
        end
        if (i_burst_end) begin
            n_pos = '0;
        end else if (w_in_frame) begin
            n_pos = r_pos + 1'b1;
        end else begin
            n_pos = POS_FULL;
        end
    end

    always_comb begin
        o_push        = w_accept && i_burst_end;
        o_req.level   = {w_frame[3], w_frame[4]};
        o_req.volume  = {w_frame[5], w_frame[6]};
        o_req.flag    = w_frame[7];
        o_req.mode    = w_frame[8];
        priority if (w_frame[0] != HDR_SYNC || w_frame[1] != HDR_TYPE
                     || w_frame[2] != HDR_LEN) begin
            o_req.status = ST_HDR_ERR;
        end else if (w_frame[POS_RESERVED] != 8'd0) begin
            o_req.status = ST_INVALID;
        end else if (n_sum != w_frame[POS_CSUM]) begin
            o_req.status = ST_CSUM_ERR;
        end else begin
            o_req.status = ST_GOOD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
            for (int k = 0; k < FRAME_LEN; k++) begin
                r_store[k] <= '0;
            end
        end else if (w_accept) begin
            r_pos <= n_pos;
            r_sum <= n_sum;
            if (w_in_frame) begin
                r_store[r_pos] <= i_rx_byte;
            end
        end
    end

endmodule

@@ hdl/sfc_queue.sv @@
// short request queue between the front end and the back end
// depends on sfc_pkg
module sfc_queue
    import sfc_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_check_req i_req,
    output logic       o_full,
    output logic       o_valid,
    input  logic       i_pop,
    output t_check_req o_req
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_check_req       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_req   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
`endif

endmodule

@@ hdl/sfc_back.sv @@
// back end: configuration registers, reading and counter updates, result register
// depends on sfc_pkg
module sfc_back
    import sfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_q_valid,
    input  t_check_req            i_req,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_result               o_result
);

    logic [2:0]  r_alarm_mask;
    logic [15:0] r_vol_thr;
    logic [15:0] r_lvl_thr;

    logic        r_out_valid;
    t_status     r_status;
    logic [15:0] r_level;
    logic [15:0] r_volume;
    logic [7:0]  r_flag;
    logic [7:0]  r_mode;
    logic        r_warning;
    logic [7:0]  r_pkt_cnt;
    logic [15:0] r_hdr_cnt;
    logic [15:0] r_inv_cnt;
    logic [15:0] r_csum_cnt;
    logic        n_warning;

    assign o_pop = i_q_valid && (!r_out_valid || i_ready);

    always_comb begin
        n_warning = (r_alarm_mask[0] && i_req.flag != 8'd0)
                 || (r_alarm_mask[1] && i_req.volume < r_vol_thr)
                 || (r_alarm_mask[2] && i_req.level < r_lvl_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_mask <= '0;
            r_vol_thr    <= '0;
            r_lvl_thr    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALARM_MASK: r_alarm_mask <= i_cfg_data[2:0];
                CFG_VOL_THR:    r_vol_thr    <= i_cfg_data;
                CFG_LVL_THR:    r_lvl_thr    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_status    <= ST_GOOD;
            r_level     <= '0;
            r_volume    <= '0;
            r_flag      <= '0;
            r_mode      <= '0;
            r_warning   <= 1'b0;
            r_pkt_cnt   <= '0;
            r_hdr_cnt   <= '0;
            r_inv_cnt   <= '0;
            r_csum_cnt  <= '0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_status <= i_req.status;
                unique case (i_req.status)
                    ST_GOOD: begin
                        r_level   <= i_req.level;
                        r_volume  <= i_req.volume;
                        r_flag    <= i_req.flag;
                        r_mode    <= i_req.mode;
                        r_warning <= n_warning;
                        r_pkt_cnt <= r_pkt_cnt + 1'b1;
                    end
                    ST_HDR_ERR: begin
                        r_warning <= 1'b0;
                        r_hdr_cnt <= r_hdr_cnt + 1'b1;
                    end
                    ST_INVALID: begin
                        r_warning <= 1'b0;
                        r_inv_cnt <= r_inv_cnt + 1'b1;
                    end
                    ST_CSUM_ERR: begin
                        r_warning  <= 1'b0;
                        r_csum_cnt <= r_csum_cnt + 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_valid                  = r_out_valid;
    assign o_result.status          = r_status;
    assign o_result.level_value     = r_level;
    assign o_result.volume_value    = r_volume;
    assign o_result.flag_byte       = r_flag;
    assign o_result.mode_byte       = r_mode;
    assign o_result.warning         = r_warning;
    assign o_result.packet_count    = r_pkt_cnt;
    assign o_result.header_errors   = r_hdr_cnt;
    assign o_result.invalid_errors  = r_inv_cnt;
    assign o_result.checksum_errors = r_csum_cnt;

`ifndef SYNTHESIS
    a_good_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_req.status == ST_GOOD |=> r_pkt_cnt == 8'($past(r_pkt_cnt) + 8'd1))
        else $error("good frame not counted");
    a_hdr_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_req.status == ST_HDR_ERR
        |=> r_hdr_cnt == 16'($past(r_hdr_cnt) + 16'd1) && r_pkt_cnt == $past(r_pkt_cnt))
        else $error("header error miscounted");
    a_warn_good_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_warning |-> r_status == ST_GOOD)
        else $error("warning on a failed frame");
`endif

endmodule

@@ hdl/sensor_frame_checker.sv @@
// sensor frame checker top level: front end, request queue, back end
// depends on sfc_pkg, sfc_in_if, sfc_out_if, sfc_front, sfc_queue, sfc_back
//
//   channel   dir   handshake          payload
//   i_in      in    valid / ready      rx_byte, burst_end
//   o_out     out   valid / ready      status, readings, warning, counters
//   cfg       in    i_cfg_we           i_cfg_idx, i_cfg_data
//
// one byte per cycle unless stalled; results pass queue and result register
// the front stalls only when the request queue is full, the queue fills only
// while the result register waits on o_out.ready
// reset is synchronous and clears the frame store, counters and readings
module sensor_frame_checker
    import sfc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sfc_in_if.sink                i_in,
    sfc_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic       w_push;
    logic       w_full;
    logic       w_q_valid;
    logic       w_pop;
    t_check_req w_push_req;
    t_check_req w_pop_req;
    t_result    w_result;

    sfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_rx_byte   (i_in.rx_byte),
        .i_burst_end (i_in.burst_end),
        .o_ready     (i_in.ready),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_req       (w_push_req)
    );

    sfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_push_req),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_req   (w_pop_req)
    );

    sfc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (w_q_valid),
        .i_req      (w_pop_req),
        .o_pop      (w_pop),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_result   (w_result)
    );

    assign o_out.status          = w_result.status;
    assign o_out.level_value     = w_result.level_value;
    assign o_out.volume_value    = w_result.volume_value;
    assign o_out.flag_byte       = w_result.flag_byte;
    assign o_out.mode_byte       = w_result.mode_byte;
    assign o_out.warning         = w_result.warning;
    assign o_out.packet_count    = w_result.packet_count;
    assign o_out.header_errors   = w_result.header_errors;
    assign o_out.invalid_errors  = w_result.invalid_errors;
    assign o_out.checksum_errors = w_result.checksum_errors;

endmodule

@@ tb/tb_top.sv @@
// self-checking bench for sensor_frame_checker: random byte bursts against a frame predictor
// with random sender gaps and receiver stalls, plus directed, counter-wrap and backpressure tests
// depends on sfc_pkg, sfc_in_if, sfc_out_if and the sensor_frame_checker rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sfc_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RST_CYCLES     = 11;
    localparam int DRAIN_CYCLES   = 6;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SWEEP_PHASES   = 6;
    localparam int SWEEP_FRAMES   = 18;
    localparam int WRAP_BURSTS    = 260;
    localparam int HOLD_BURSTS    = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef logic [FRAME_LEN-1:0][7:0] t_frame;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    sfc_in_if  in_if ();
    sfc_out_if out_if ();

    sensor_frame_checker u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predicted block state
    t_frame      pred_frame    = '0;
    int          pred_pos      = 0;
    logic [15:0] pred_level    = '0;
    logic [15:0] pred_volume   = '0;
    logic [7:0]  pred_flag     = '0;
    logic [7:0]  pred_mode     = '0;
    logic        pred_warn     = 1'b0;
    logic [7:0]  pred_packets  = '0;
    logic [15:0] pred_hdr_errs = '0;
    logic [15:0] pred_inv_errs = '0;
    logic [15:0] pred_sum_errs = '0;
    logic [2:0]  alarm_mask    = '0;
    logic [15:0] vol_thr       = '0;
    logic [15:0] lvl_thr       = '0;

    t_result frame_reports_due[$];
    int      error_count  = 0;
    int      stuck_cycles = 0;

    bit gaps_on    = 1'b0;
    int burst_left = 0;
    bit stalls_on  = 1'b0;
    bit rx_stall   = 1'b0;
    int rx_left    = 0;
    bit hold_req   = 1'b0;
    int hold_left  = 0;

    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic [7:0] frame_sum(input t_frame fr);
        logic [7:0] s;
        s = '0;
        for (int k = 0; k < POS_CSUM; k++) s += fr[k];
        return s;
    endfunction

    function automatic t_frame make_frame(input logic [15:0] level, input logic [15:0] volume,
                                          input logic [7:0] flag, input logic [7:0] mode);
        t_frame fr;
        fr[0] = HDR_SYNC;
        fr[1] = HDR_TYPE;
        fr[2] = HDR_LEN;
        fr[3] = level[15:8];
        fr[4] = level[7:0];
        fr[5] = volume[15:8];
        fr[6] = volume[7:0];
        fr[7] = flag;
        fr[8] = mode;
        fr[POS_RESERVED] = 8'h00;
        fr[POS_CSUM] = frame_sum(fr);
        return fr;
    endfunction

    function automatic logic [15:0] pick_reading(input logic [15:0] thr);
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return thr;
            3: return thr - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // store one accepted byte, check the frame at the end of a burst
    task automatic track_frame_byte(input logic [7:0] b, input logic last);
        t_result res;
        if (pred_pos < FRAME_LEN) begin
            pred_frame[pred_pos] = b;
            pred_pos++;
        end
        if (last) begin
            pred_warn = 1'b0;
            if (pred_frame[0] != HDR_SYNC || pred_frame[1] != HDR_TYPE ||
                pred_frame[2] != HDR_LEN) begin
                pred_hdr_errs++;
                res.status = ST_HDR_ERR;
            end else if (pred_frame[POS_RESERVED] != 8'h00) begin
                pred_inv_errs++;
                res.status = ST_INVALID;
            end else if (frame_sum(pred_frame) != pred_frame[POS_CSUM]) begin
                pred_sum_errs++;
                res.status = ST_CSUM_ERR;
            end else begin
                pred_level  = {pred_frame[3], pred_frame[4]};
                pred_volume = {pred_frame[5], pred_frame[6]};
                pred_flag   = pred_frame[7];
                pred_mode   = pred_frame[8];
                if (alarm_mask[0] && pred_flag != 8'h00) pred_warn = 1'b1;
                if (alarm_mask[1] && pred_volume < vol_thr) pred_warn = 1'b1;
                if (alarm_mask[2] && pred_level < lvl_thr) pred_warn = 1'b1;
                pred_packets++;
                res.status = ST_GOOD;
            end
            pred_pos = 0;
            res.level_value     = pred_level;
            res.volume_value    = pred_volume;
            res.flag_byte       = pred_flag;
            res.mode_byte       = pred_mode;
            res.warning         = pred_warn;
            res.packet_count    = pred_packets;
            res.header_errors   = pred_hdr_errs;
            res.invalid_errors  = pred_inv_errs;
            res.checksum_errors = pred_sum_errs;
            frame_reports_due.push_back(res);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        in_if.valid     <= 1'b1;
        in_if.rx_byte   <= b;
        in_if.burst_end <= last;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        track_frame_byte(b, last);
    endtask

    // bytes past the frame length are random filler
    task automatic send_burst(input t_frame fr, input int len);
        for (int k = 0; k < len; k++)
            send_byte((k < FRAME_LEN) ? fr[k] : 8'($urandom), k == len - 1);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (frame_reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ALARM_MASK: alarm_mask = data[2:0];
            CFG_VOL_THR:    vol_thr = data;
            CFG_LVL_THR:    lvl_thr = data;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [2:0] mask, input logic [15:0] vthr,
                             input logic [15:0] lthr);
        write_reg(CFG_ALARM_MASK, {13'($urandom), mask});
        write_reg(CFG_VOL_THR, vthr);
        write_reg(CFG_LVL_THR, lthr);
        write_reg(CFG_UNUSED, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_frame();
        t_frame fr;
        int     len;
        int     pick;
        int     idx;
        fr = make_frame(pick_reading(lvl_thr), pick_reading(vol_thr),
                        $urandom_range(0, 1) ? 8'($urandom) : 8'h00, 8'($urandom));
        len = FRAME_LEN;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
        end else if (pick < 63) begin
            idx = $urandom_range(0, 2);
            fr[idx] = fr[idx] ^ 8'($urandom_range(1, 255));
            fr[POS_CSUM] = frame_sum(fr);
        end else if (pick < 71) begin
            fr[POS_RESERVED] = 8'($urandom_range(1, 255));
            fr[POS_CSUM] = frame_sum(fr);
        end else if (pick < 79) begin
            fr[POS_CSUM] = fr[POS_CSUM] ^ 8'($urandom_range(1, 255));
        end else if (pick < 86) begin
            len = $urandom_range(1, FRAME_LEN - 1);
        end else if (pick < 93) begin
            len = $urandom_range(FRAME_LEN + 1, FRAME_LEN + 6);
        end else begin
            for (int k = 0; k < FRAME_LEN; k++) fr[k] = 8'($urandom);
            len = $urandom_range(1, 14);
        end
        send_burst(fr, len);
    endtask

    task automatic test_directed();
        t_frame fr;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        fr = make_frame(16'hFFFF, 16'h0000, 8'hFF, 8'h80);
        send_burst(fr, FRAME_LEN);
        // header broken by a one-byte burst
        send_byte(8'h00, 1'b1);
        // short burst changes the level, stale checksum
        fr[3] = ~fr[3];
        send_burst(fr, 4);
        // long burst with reserved byte set
        fr = make_frame(16'h0000, 16'hFFFF, 8'h00, 8'h7F);
        fr[POS_RESERVED] = 8'h01;
        fr[POS_CSUM] = frame_sum(fr);
        send_burst(fr, FRAME_LEN + 1);
        wait_idle();
    endtask

    task automatic test_config_sweep();
        for (int phase = 0; phase < SWEEP_PHASES; phase++) begin
            case (phase)
                0: configure(3'd7, 16'hFFFF, 16'hFFFF);
                1: configure(3'd7, 16'h0000, 16'h0000);
                2: configure(3'd1, 16'($urandom), 16'($urandom));
                3: configure(3'd2, 16'($urandom), 16'($urandom));
                4: configure(3'd4, 16'($urandom), 16'($urandom));
                default: configure(3'($urandom), 16'($urandom), 16'($urandom));
            endcase
            gaps_on   = (phase != 1);
            stalls_on = (phase != 2);
            repeat (SWEEP_FRAMES) send_random_frame();
            wait_idle();
        end
    endtask

    // a stored good frame re-checked by one-byte bursts wraps the packet counter
    task automatic test_packet_wrap();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_burst(make_frame(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom)),
                   FRAME_LEN);
        repeat (WRAP_BURSTS) send_byte(HDR_SYNC, 1'b1);
        wait_idle();
    endtask

    task automatic test_backpressure();
        gaps_on   = 1'b0;
        stalls_on = 1'b1;
        send_burst(make_frame(16'($urandom), 16'($urandom), 8'h00, 8'($urandom)), FRAME_LEN);
        hold_req = 1'b1;
        repeat (HOLD_BURSTS) send_byte(HDR_SYNC, 1'b1);
        wait_idle();
    endtask

    task automatic check_frame_report();
        t_result want;
        if (frame_reports_due.size() == 0) begin
            report_error("result with no request pending");
        end else begin
            want = frame_reports_due.pop_front();
            if (out_if.status !== want.status)
                report_error($sformatf("status got %0d expected %0d", out_if.status, want.status));
            if (out_if.level_value !== want.level_value)
                report_error($sformatf("level_value got %h expected %h",
                                       out_if.level_value, want.level_value));
            if (out_if.volume_value !== want.volume_value)
                report_error($sformatf("volume_value got %h expected %h",
                                       out_if.volume_value, want.volume_value));
            if (out_if.flag_byte !== want.flag_byte)
                report_error($sformatf("flag_byte got %h expected %h",
                                       out_if.flag_byte, want.flag_byte));
            if (out_if.mode_byte !== want.mode_byte)
                report_error($sformatf("mode_byte got %h expected %h",
                                       out_if.mode_byte, want.mode_byte));
            if (out_if.warning !== want.warning)
                report_error($sformatf("warning got %b expected %b",
                                       out_if.warning, want.warning));
            if (out_if.packet_count !== want.packet_count)
                report_error($sformatf("packet_count got %h expected %h",
                                       out_if.packet_count, want.packet_count));
            if (out_if.header_errors !== want.header_errors)
                report_error($sformatf("header_errors got %h expected %h",
                                       out_if.header_errors, want.header_errors));
            if (out_if.invalid_errors !== want.invalid_errors)
                report_error($sformatf("invalid_errors got %h expected %h",
                                       out_if.invalid_errors, want.invalid_errors));
            if (out_if.checksum_errors !== want.checksum_errors)
                report_error($sformatf("checksum_errors got %h expected %h",
                                       out_if.checksum_errors, want.checksum_errors));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            check_frame_report();
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (!stalls_on) begin
            out_if.ready <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_stall = !rx_stall;
                rx_left  = rx_stall ? $urandom_range(1, 6) : $urandom_range(1, 16);
            end
            rx_left--;
            out_if.ready <= !rx_stall;
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        in_if.valid     = 1'b0;
        in_if.rx_byte   = '0;
        in_if.burst_end = 1'b0;
        out_if.ready    = 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_config_sweep();
        test_packet_wrap();
        test_backpressure();
        wait_idle();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
